@@ rtl/dsa_pkg.sv @@
package dsa_pkg;

  localparam int unsigned MaxSlotsDefault = 1024;

  localparam int unsigned AddrW    = 48;
  localparam int unsigned StrideW  = 13;
  localparam int unsigned CntW     = 11;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned FailW    = 32;
  localparam int unsigned ProdW    = CntW + StrideW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = AddrW;
  // wide enough to hold slot-count values up to 2**17 - 1
  localparam int unsigned CmpW     = 17;

  localparam logic [StrideW-1:0] StrideReset   = StrideW'(32);
  localparam logic [CntW-1:0]    CapacityReset = CntW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeapBase   = 2'd0,
    CfgSlotStride = 2'd1,
    CfgCapacity   = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KindAlloc   = 1'b0,
    KindRelease = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    StAllocated   = 3'd0,
    StExhausted   = 3'd1,
    StReleased    = 3'd2,
    StInvalid     = 3'd3,
    StNeverIssued = 3'd4,
    StAlreadyFree = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FsmIdle = 2'd0,
    FsmExec = 2'd1,
    FsmDone = 2'd2
  } fsm_e;

  typedef struct packed {
    kind_e            kind;
    logic             release_valid;
    logic [SlotW-1:0] release_slot;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] granted_slot;
    logic [AddrW-1:0] granted_address;
    logic [CntW-1:0]  used_count;
    logic [FailW-1:0] failure_count;
  } rsp_t;

endpackage

@@ rtl/dsa_req_if.sv @@
interface dsa_req_if import dsa_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/dsa_rsp_if.sv @@
interface dsa_rsp_if import dsa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/descriptor_slot_allocator.sv @@
// Descriptor slot allocator. Each request passes through three steps: the
// transfer cycle reads the free-slot stack and the free-mark memory, the next cycle
// does the read-modify-write of both memories and the counters and forms
// slot times stride, and the done state adds heap_base and loads the result
// register once it is free. A new request is taken once the previous one has reached the
// result register, so a waiting result does not hold off the next request.
// Both memories are MAX_SLOTS deep and need no clearing pass: a slot's free
// mark is written when the slot is first issued, and only slots below the
// bump pointer are ever used. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; unmapped register indexes are ignored.
module descriptor_slot_allocator import dsa_pkg::*; #(
  parameter int unsigned MAX_SLOTS = MaxSlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dsa_req_if.sink             req_i,
  dsa_rsp_if.source           rsp_o
);

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [CmpW-1:0] MaxSlotsV = CmpW'(MAX_SLOTS);

  logic [AddrW-1:0]   heap_base_q;
  logic [StrideW-1:0] slot_stride_q;
  logic [CntW-1:0]    capacity_q;

  logic [CntW-1:0]  free_depth_q, free_depth_d;
  logic [CntW-1:0]  next_fresh_q, next_fresh_d;
  logic [CntW-1:0]  in_use_q, in_use_d;
  logic [FailW-1:0] failures_q, failures_d;

  fsm_e state_q, state_d;
  req_t req_q;

  logic [SlotW-1:0] stack_mem [MAX_SLOTS];
  logic             mark_mem  [MAX_SLOTS];
  logic [SlotW-1:0] stk_rd_q;
  logic             mark_rd_q;

  logic          stk_we, mark_we, mark_wdata;
  logic [AW-1:0] mark_waddr;

  status_e          status_d, status_q;
  logic [SlotW-1:0] slot_d, slot_q;
  logic [CntW-1:0]  grant_idx;

  logic       accept, in_ready, exec_en, out_load;
  logic       out_valid_q;
  rsp_t       rsp_q;
  logic [AddrW-1:0] grant_addr;

  logic [CmpW-1:0] eff_cap;
  logic            can_pop, can_bump, never_issued;

  assign accept = req_i.valid && in_ready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q   <= '0;
      slot_stride_q <= StrideReset;
      capacity_q    <= CapacityReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgHeapBase:   heap_base_q   <= cfg_data_i[AddrW-1:0];
        CfgSlotStride: slot_stride_q <= cfg_data_i[StrideW-1:0];
        CfgCapacity:   capacity_q    <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FsmIdle: if (accept) state_d = FsmExec;
      FsmExec: state_d = FsmDone;
      FsmDone: if (out_load) state_d = FsmIdle;
      default: state_d = FsmIdle;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      FsmIdle: in_ready = 1'b1;
      FsmExec: exec_en  = 1'b1;
      FsmDone: out_load = !out_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FsmIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.payload;
    end
  end

  // memories: read on the transfer cycle, written during execute
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[AW'(free_depth_q)] <= req_q.release_slot;
    end
    if (accept) begin
      stk_rd_q <= stack_mem[AW'(free_depth_q - CntW'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (accept) begin
      mark_rd_q <= mark_mem[AW'(req_i.payload.release_slot)];
    end
  end

  // execute: decide, update counters and memories
  assign eff_cap  = (CmpW'(capacity_q) > MaxSlotsV) ? MaxSlotsV : CmpW'(capacity_q);
  assign can_pop  = (free_depth_q != '0) && (CmpW'(free_depth_q) <= MaxSlotsV);
  assign can_bump = CmpW'(next_fresh_q) < eff_cap;
  assign never_issued = (CntW'(req_q.release_slot) >= next_fresh_q) ||
                        (CmpW'(req_q.release_slot) >= MaxSlotsV);

  always_comb begin
    free_depth_d = free_depth_q;
    next_fresh_d = next_fresh_q;
    in_use_d     = in_use_q;
    failures_d   = failures_q;
    stk_we       = 1'b0;
    mark_we      = 1'b0;
    mark_wdata   = 1'b0;
    mark_waddr   = AW'(req_q.release_slot);
    status_d     = StExhausted;
    slot_d       = '0;
    grant_idx    = '0;
    if (exec_en) begin
      if (req_q.kind == KindAlloc) begin
        if (can_pop || can_bump) begin
          status_d = StAllocated;
          mark_we  = 1'b1;
          if (in_use_q != '1) in_use_d = in_use_q + CntW'(1);
          if (can_pop) begin
            slot_d       = stk_rd_q;
            grant_idx    = CntW'(stk_rd_q);
            mark_waddr   = AW'(stk_rd_q);
            free_depth_d = free_depth_q - CntW'(1);
          end else begin
            slot_d       = next_fresh_q[SlotW-1:0];
            grant_idx    = next_fresh_q;
            mark_waddr   = AW'(next_fresh_q);
            next_fresh_d = next_fresh_q + CntW'(1);
          end
        end else begin
          status_d = StExhausted;
          if (failures_q != '1) failures_d = failures_q + FailW'(1);
        end
      end else begin
        if (!req_q.release_valid) begin
          status_d = StInvalid;
        end else if (never_issued) begin
          status_d = StNeverIssued;
        end else if (mark_rd_q || (CmpW'(free_depth_q) >= MaxSlotsV)) begin
          status_d = StAlreadyFree;
        end else begin
          status_d     = StReleased;
          stk_we       = 1'b1;
          mark_we      = 1'b1;
          mark_wdata   = 1'b1;
          free_depth_d = free_depth_q + CntW'(1);
          if (in_use_q != '0) in_use_d = in_use_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_depth_q <= '0;
      next_fresh_q <= '0;
      in_use_q     <= '0;
      failures_q   <= '0;
    end else begin
      free_depth_q <= free_depth_d;
      next_fresh_q <= next_fresh_d;
      in_use_q     <= in_use_d;
      failures_q   <= failures_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_en) begin
      status_q <= status_d;
      slot_q   <= slot_d;
    end
  end

  dsa_addr_unit u_addr (
    .clk_i     (clk_i),
    .calc_en_i (exec_en),
    .grant_i   (status_d == StAllocated),
    .slot_i    (grant_idx),
    .stride_i  (slot_stride_q),
    .base_i    (heap_base_q),
    .addr_o    (grant_addr)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsp_q.status          <= status_q;
      rsp_q.granted_slot    <= slot_q;
      rsp_q.granted_address <= grant_addr;
      rsp_q.used_count      <= in_use_q;
      rsp_q.failure_count   <= failures_q;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

  // the free stack never holds more entries than there are issued slots
  a_depth_le_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_depth_q <= next_fresh_q)
    else $error("free stack deeper than issued slots");

  a_depth_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(free_depth_q) <= MaxSlotsV)
    else $error("free stack overflow");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == FsmExec))
    else $error("accepted request not executed");

  a_grant_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (rsp_q.status == StAllocated)) |->
      (CntW'(rsp_q.granted_slot) < next_fresh_q))
    else $error("granted slot beyond bump pointer");

endmodule

@@ rtl/dsa_addr_unit.sv @@
module dsa_addr_unit import dsa_pkg::*; (
  input  logic               clk_i,
  input  logic               calc_en_i,
  input  logic               grant_i,
  input  logic [CntW-1:0]    slot_i,
  input  logic [StrideW-1:0] stride_i,
  input  logic [AddrW-1:0]   base_i,
  output logic [AddrW-1:0]   addr_o
);

  logic [ProdW-1:0] prod_q;
  logic             grant_q;

  // product registered here, base added combinationally after the register
  always_ff @(posedge clk_i) begin
    if (calc_en_i) begin
      prod_q  <= ProdW'(slot_i) * ProdW'(stride_i);
      grant_q <= grant_i;
    end
  end

  assign addr_o = grant_q ? (base_i + AddrW'(prod_q)) : '0;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import dsa_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnmapped = 2'd3;
  localparam int unsigned StallCycles = 120;
  localparam int unsigned DrainCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // testbench-owned copies so every block input is known from time zero
  logic req_valid = 1'b0;
  req_t req_data = '0;
  logic rsp_ready = 1'b0;

  dsa_req_if req_if ();
  dsa_rsp_if rsp_if ();

  assign req_if.valid   = req_valid;
  assign req_if.payload = req_data;
  assign rsp_if.ready   = rsp_ready;

  descriptor_slot_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // allocator shadow state
  logic [AddrW-1:0]   heap_base;
  logic [StrideW-1:0] slot_stride;
  logic [CntW-1:0]    slot_capacity;
  logic [SlotW-1:0]   freed_slots [MaxSlotsDefault];
  bit                 on_free_list [MaxSlotsDefault];
  logic [CntW-1:0]    freed_depth;
  logic [CntW-1:0]    bump_ptr;
  logic [CntW-1:0]    slots_in_use;
  logic [FailW-1:0]   alloc_failures;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 56;
  bit          stall_armed = 1'b0;
  bit          stall_done = 1'b0;
  int unsigned stall_left = 0;

  function automatic rsp_t predict_response(req_t r);
    rsp_t             rsp;
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  eff_cap;
    bit               granted;
    rsp = '0;
    slot = '0;
    granted = 1'b0;
    eff_cap = (slot_capacity > CntW'(MaxSlotsDefault)) ? CntW'(MaxSlotsDefault)
                                                        : slot_capacity;
    if (r.kind == KindAlloc) begin
      if (freed_depth != 0) begin
        freed_depth = freed_depth - 1'b1;
        slot = freed_slots[freed_depth];
        on_free_list[slot] = 1'b0;
        granted = 1'b1;
      end else if (bump_ptr < eff_cap) begin
        slot = bump_ptr[SlotW-1:0];
        bump_ptr = bump_ptr + 1'b1;
        granted = 1'b1;
      end
      if (granted) begin
        if (slots_in_use != '1) slots_in_use = slots_in_use + 1'b1;
        rsp.status = StAllocated;
        rsp.granted_slot = slot;
        rsp.granted_address = heap_base + AddrW'(slot) * AddrW'(slot_stride);
      end else begin
        if (alloc_failures != '1) alloc_failures = alloc_failures + 1'b1;
        rsp.status = StExhausted;
      end
    end else begin
      if (!r.release_valid) begin
        rsp.status = StInvalid;
      end else if (CntW'(r.release_slot) >= bump_ptr) begin
        rsp.status = StNeverIssued;
      end else if (on_free_list[r.release_slot]) begin
        rsp.status = StAlreadyFree;
      end else begin
        freed_slots[freed_depth] = r.release_slot;
        freed_depth = freed_depth + 1'b1;
        on_free_list[r.release_slot] = 1'b1;
        if (slots_in_use != 0) slots_in_use = slots_in_use - 1'b1;
        rsp.status = StReleased;
      end
    end
    rsp.used_count = slots_in_use;
    rsp.failure_count = alloc_failures;
    return rsp;
  endfunction

  function automatic req_t alloc_req();
    req_t r;
    r = '0;
    r.kind = KindAlloc;
    return r;
  endfunction

  function automatic req_t release_req(logic valid, logic [SlotW-1:0] slot);
    req_t r;
    r.kind = KindRelease;
    r.release_valid = valid;
    r.release_slot = slot;
    return r;
  endfunction

  // slightly more allocations than releases; releases mostly name slots up to span, plus invalid handles and wild slots
  function automatic req_t random_request(int unsigned span);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.kind = KindAlloc;
    r.release_valid = $urandom_range(0, 1);
    r.release_slot = $urandom_range(0, MaxSlotsDefault - 1);
    if (pick >= 52) begin
      r.kind = KindRelease;
      if (pick < 60) begin
        r.release_valid = 1'b0;
      end else begin
        r.release_valid = 1'b1;
        if (pick >= 68) r.release_slot = $urandom_range(0, span);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic add_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CfgHeapBase:   heap_base = data[AddrW-1:0];
      CfgSlotStride: slot_stride = data[StrideW-1:0];
      CfgCapacity:   slot_capacity = data[CntW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_random(int unsigned count, int unsigned span);
    repeat (count) add_req(random_request(span));
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni && (!req_valid || req_if.ready)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_data <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response sink, with one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        rsp_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (stall_armed && !stall_done) begin
        stall_done <= 1'b1;
        stall_left <= StallCycles;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // monitor: check result transfers, then predict accepted requests
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.payload;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result, status", got.status, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.granted_slot !== want.granted_slot)
            report_mismatch("granted_slot", got.granted_slot, want.granted_slot);
          if (got.granted_address !== want.granted_address)
            report_mismatch("granted_address", got.granted_address, want.granted_address);
          if (got.used_count !== want.used_count)
            report_mismatch("used_count", got.used_count, want.used_count);
          if (got.failure_count !== want.failure_count)
            report_mismatch("failure_count", got.failure_count, want.failure_count);
        end
      end
      if (req_if.valid && req_if.ready)
        expected_rsps.insert(expected_rsps.size(), predict_response(req_if.payload));
    end
  end

  initial begin
    heap_base = '0;
    slot_stride = StrideReset;
    slot_capacity = CapacityReset;
    freed_depth = '0;
    bump_ptr = '0;
    slots_in_use = '0;
    alloc_failures = '0;
    foreach (on_free_list[i]) on_free_list[i] = 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // small table near the top of the address space, widest stride
    cfg_write(CfgHeapBase, CfgDataW'(48'hFFFF_FFFF_FFF0));
    cfg_write(CfgSlotStride, CfgDataW'(13'h1FFF));
    cfg_write(CfgCapacity, CfgDataW'(4));
    add_req(release_req(1'b0, 10'h3FF));
    add_req(release_req(1'b1, 10'd0));
    repeat (5) add_req(alloc_req());
    add_req(release_req(1'b1, 10'd3));
    add_req(release_req(1'b1, 10'd3));
    add_req(release_req(1'b1, 10'd1));
    add_req(alloc_req());
    add_req(alloc_req());
    add_req(release_req(1'b1, 10'd4));
    add_req(release_req(1'b1, 10'h3FF));
    wait_drained();

    // unmapped index must not land anywhere; zero stride; capacity cut to zero
    cfg_write(CfgUnmapped, '1);
    cfg_write(CfgSlotStride, '0);
    cfg_write(CfgCapacity, '0);
    cfg_write(CfgHeapBase, CfgDataW'(48'h1234_5678_9ABC));
    add_req(release_req(1'b1, 10'd2));
    add_req(alloc_req());
    add_req(alloc_req());
    add_req(release_req(1'b1, 10'd0));
    add_req(alloc_req());
    wait_drained();

    cfg_write(CfgHeapBase, CfgDataW'({$urandom, $urandom}));
    cfg_write(CfgSlotStride, CfgDataW'($urandom_range(1, 4096)));
    cfg_write(CfgCapacity, CfgDataW'(48));
    queue_random(180, 60);
    stall_armed = 1'b1;
    wait_drained();

    send_idle_pct = 56;
    recv_idle_pct = 26;
    // capacity beyond the table size is clamped
    cfg_write(CfgHeapBase, '1);
    cfg_write(CfgSlotStride, CfgDataW'(4096));
    cfg_write(CfgCapacity, CfgDataW'(11'h7FF));
    queue_random(180, 300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(CfgHeapBase, CfgDataW'({$urandom, $urandom}));
    cfg_write(CfgSlotStride, CfgDataW'($urandom_range(1, 8191)));
    cfg_write(CfgCapacity, CfgDataW'(MaxSlotsDefault));
    queue_random(190, 400);
    wait_drained();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
